// ===== rtl/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// pst_pkg: shared types and constants for the priority sorted table
// field widths, command and status codes, controller to datapath structs
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned PRIO_W = 16;
  localparam int unsigned RPOS_W = 6;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned POS_W  = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_CLEAR,
    OP_READ_ISSUE,
    OP_READ_TAKE,
    OP_SCAN,
    OP_DUP,
    OP_REM_START,
    OP_FAIL,
    OP_INS_START,
    OP_INS_SHIFT,
    OP_INS_PLACE,
    OP_REM_SHIFT,
    OP_REM_FINISH,
    OP_LOAD_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e code;
  } dp_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  hit;
    logic  more;
    logic  full;
    logic  ptr_zero;
    logic  behind;
    logic  rem_more;
    logic  rsp_free;
  } dp_stat_t;

endpackage

// ===== rtl/pst_if.sv =====
// ----------------------------------------------------------------------------
// pst channel interfaces
// command, result and configuration channels, valid/ready each
// ----------------------------------------------------------------------------
interface pst_cmd_if;
  logic                              valid;
  logic                              ready;
  logic        [pst_pkg::KIND_W-1:0] kind;
  logic        [pst_pkg::ID_W-1:0]   entry_id;
  logic signed [pst_pkg::PRIO_W-1:0] entry_priority;
  logic        [pst_pkg::RPOS_W-1:0] read_position;

  modport source (output valid, kind, entry_id, entry_priority, read_position,
                  input ready);
  modport sink (input valid, kind, entry_id, entry_priority, read_position,
                output ready);
endinterface

interface pst_rsp_if;
  logic                              valid;
  logic                              ready;
  logic        [pst_pkg::ST_W-1:0]   status;
  logic        [pst_pkg::CNT_W-1:0]  entry_count;
  logic        [pst_pkg::ID_W-1:0]   out_id;
  logic signed [pst_pkg::PRIO_W-1:0] out_priority;
  logic        [pst_pkg::POS_W-1:0]  final_position;

  modport source (output valid, status, entry_count, out_id, out_priority,
                  final_position, input ready);
  modport sink (input valid, status, entry_count, out_id, out_priority,
                final_position, output ready);
endinterface

interface pst_cfg_if;
  logic valid;
  logic ready;
  logic ascending_order;

  modport source (output valid, ascending_order, input ready);
  modport sink (input valid, ascending_order, output ready);
endinterface

// ===== rtl/priority_sorted_table.sv =====
// ----------------------------------------------------------------------------
// priority_sorted_table: ordered table of identifier / signed priority pairs
// ----------------------------------------------------------------------------
// usage:
//   cmd_i  carries one command item: insert, remove by id, clear or read at
//          a position; exactly one result item per command leaves on rsp_o
//   cfg_i  writes the ascending_order bit; it is always ready and is meant to
//          be written only while no command is in flight
// ordering: descending priority unless ascending_order is set; ties keep
//   arrival order; a register change affects only later inserts
// walk (n = entries held): clear and read walk no entries; remove and
//   insert search up to n entries, then the shift walks up to n more
// throughput: one command at a time; the single read port of the entry
//   memory is walked one entry per cycle, and a new command is accepted
//   only once the last one has loaded its result
// a finished result sits in an output register; the next command is
//   accepted while it waits, and the block stalls only before loading the
//   following result when the receiver still has not taken it
// reset: the table empties and the order goes to descending; no clearing
//   pass is needed: entries at or above the count are ignored when read
// ----------------------------------------------------------------------------
module priority_sorted_table #(
  parameter int unsigned CAPACITY = pst_pkg::CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pst_cmd_if.sink   cmd_i,
  pst_rsp_if.source rsp_o,
  pst_cfg_if.sink   cfg_i
);

  // controller to datapath command and status
  pst_pkg::dp_cmd_t  dp_cmd;
  pst_pkg::dp_stat_t dp_stat;

  // the config register is a single flop, so writes never stall
  assign cfg_i.ready = 1'b1;

  pst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  // datapath holds the entry memory, counters and the result register
  pst_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .stat_o           (dp_stat),
    .kind_i           (cmd_i.kind),
    .entry_id_i       (cmd_i.entry_id),
    .entry_priority_i (cmd_i.entry_priority),
    .read_position_i  (cmd_i.read_position),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_ascending_i  (cfg_i.ascending_order),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_status_o     (rsp_o.status),
    .rsp_count_o      (rsp_o.entry_count),
    .rsp_id_o         (rsp_o.out_id),
    .rsp_prio_o       (rsp_o.out_priority),
    .rsp_pos_o        (rsp_o.final_position)
  );

endmodule

// ===== rtl/pst_datapath.sv =====
// ----------------------------------------------------------------------------
// pst_datapath: entry memory, pointer, occupancy and result registers
// executes one controller command per cycle
// ----------------------------------------------------------------------------
module pst_datapath #(
  parameter int unsigned CAPACITY = pst_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pst_pkg::dp_cmd_t                  cmd_i,
  output pst_pkg::dp_stat_t                 stat_o,
  input  logic        [pst_pkg::KIND_W-1:0] kind_i,
  input  logic        [pst_pkg::ID_W-1:0]   entry_id_i,
  input  logic signed [pst_pkg::PRIO_W-1:0] entry_priority_i,
  input  logic        [pst_pkg::RPOS_W-1:0] read_position_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ascending_i,
  input  logic                              rsp_ready_i,
  output logic                              rsp_valid_o,
  output logic        [pst_pkg::ST_W-1:0]   rsp_status_o,
  output logic        [pst_pkg::CNT_W-1:0]  rsp_count_o,
  output logic        [pst_pkg::ID_W-1:0]   rsp_id_o,
  output logic signed [pst_pkg::PRIO_W-1:0] rsp_prio_o,
  output logic        [pst_pkg::POS_W-1:0]  rsp_pos_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [CW-1:0] TWO = CW'(2);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  pst_pkg::entry_t mem [CAPACITY];
  pst_pkg::entry_t rd_q;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  pst_pkg::entry_t wr_data;

  // item registers
  pst_pkg::kind_e                   kind_q;
  logic [pst_pkg::ID_W-1:0]         id_q;
  logic [pst_pkg::PRIO_W-1:0]       prio_q;
  logic [pst_pkg::RPOS_W-1:0]       rpos_q;

  // control registers
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] occ_q, occ_d;
  logic          scan_v_q;
  logic          asc_q;
  logic          rsp_valid_q;

  // work result
  pst_pkg::status_e           st_q, st_d;
  logic [AW-1:0]              pos_q, pos_d;
  logic [pst_pkg::ID_W-1:0]   oid_q, oid_d;
  logic [pst_pkg::PRIO_W-1:0] oprio_q, oprio_d;

  // delivered result
  logic [pst_pkg::ST_W-1:0]   rsp_st_q;
  logic [pst_pkg::CNT_W-1:0]  rsp_cnt_q;
  logic [pst_pkg::ID_W-1:0]   rsp_id_q;
  logic [pst_pkg::PRIO_W-1:0] rsp_prio_q;
  logic [pst_pkg::POS_W-1:0]  rsp_pos_q;

  logic [CW-1:0]     ptr_m1, ptr_p1, ptr_m2, ptr_p2, occ_m1;
  logic signed [pst_pkg::PRIO_W-1:0] held_prio, fresh_prio;
  logic              behind;
  logic              rpos_ok;

  assign ptr_m1 = ptr_q - ONE;
  assign ptr_p1 = ptr_q + ONE;
  assign ptr_m2 = ptr_q - TWO;
  assign ptr_p2 = ptr_q + TWO;
  assign occ_m1 = occ_q - ONE;

  assign held_prio  = $signed(rd_q.prio);
  assign fresh_prio = $signed(prio_q);
  assign behind     = asc_q ? (held_prio > fresh_prio) : (held_prio < fresh_prio);
  assign rpos_ok    = 32'(rpos_q) < 32'(occ_q);

  assign stat_o.kind     = kind_q;
  assign stat_o.hit      = scan_v_q && (rd_q.id == id_q);
  assign stat_o.more     = ptr_q < occ_q;
  assign stat_o.full     = occ_q >= CAP;
  assign stat_o.ptr_zero = ptr_q == '0;
  assign stat_o.behind   = behind;
  assign stat_o.rem_more = ptr_p1 < occ_q;
  assign stat_o.rsp_free = !rsp_valid_q || rsp_ready_i;

  // memory port steering
  always_comb begin
    rd_addr = ptr_q[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = ptr_q[AW-1:0];
    wr_data = rd_q;
    unique case (cmd_i.op)
      pst_pkg::OP_READ_ISSUE: rd_addr = AW'(rpos_q);
      pst_pkg::OP_INS_START:  rd_addr = occ_m1[AW-1:0];
      pst_pkg::OP_INS_SHIFT: begin
        rd_addr = ptr_m2[AW-1:0];
        wr_en   = 1'b1;
      end
      pst_pkg::OP_INS_PLACE: begin
        wr_en   = 1'b1;
        wr_data = '{id: id_q, prio: prio_q};
      end
      pst_pkg::OP_REM_SHIFT: begin
        rd_addr = ptr_p2[AW-1:0];
        wr_en   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // next values of pointer, occupancy and work result
  always_comb begin
    ptr_d   = ptr_q;
    occ_d   = occ_q;
    st_d    = st_q;
    pos_d   = pos_q;
    oid_d   = oid_q;
    oprio_d = oprio_q;
    unique case (cmd_i.op)
      pst_pkg::OP_CAPTURE: begin
        ptr_d   = '0;
        st_d    = pst_pkg::ST_OK;
        pos_d   = '0;
        oid_d   = '0;
        oprio_d = '0;
      end
      pst_pkg::OP_CLEAR: occ_d = '0;
      pst_pkg::OP_READ_TAKE: begin
        if (rpos_ok) begin
          oid_d   = rd_q.id;
          oprio_d = rd_q.prio;
        end else begin
          st_d = pst_pkg::ST_EMPTY;
        end
      end
      pst_pkg::OP_SCAN: ptr_d = ptr_p1;
      pst_pkg::OP_DUP: begin
        st_d  = pst_pkg::ST_DUPLICATE;
        pos_d = ptr_m1[AW-1:0];
      end
      pst_pkg::OP_REM_START: begin
        ptr_d = ptr_m1;
        pos_d = ptr_m1[AW-1:0];
      end
      pst_pkg::OP_FAIL: begin
        st_d  = cmd_i.code;
        pos_d = '0;
      end
      pst_pkg::OP_INS_START: ptr_d = occ_q;
      pst_pkg::OP_INS_SHIFT: ptr_d = ptr_m1;
      pst_pkg::OP_INS_PLACE: begin
        occ_d = occ_q + ONE;
        pos_d = ptr_q[AW-1:0];
      end
      pst_pkg::OP_REM_SHIFT:  ptr_d = ptr_p1;
      pst_pkg::OP_REM_FINISH: occ_d = occ_m1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      occ_q       <= '0;
      scan_v_q    <= 1'b0;
      asc_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      ptr_q    <= ptr_d;
      occ_q    <= occ_d;
      scan_v_q <= cmd_i.op == pst_pkg::OP_SCAN;
      if (cfg_valid_i) begin
        asc_q <= cfg_ascending_i;
      end
      if (cmd_i.op == pst_pkg::OP_LOAD_RESULT) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == pst_pkg::OP_CAPTURE) begin
      kind_q <= pst_pkg::kind_e'(kind_i);
      id_q   <= entry_id_i;
      prio_q <= entry_priority_i;
      rpos_q <= read_position_i;
    end
    st_q    <= st_d;
    pos_q   <= pos_d;
    oid_q   <= oid_d;
    oprio_q <= oprio_d;
    if (cmd_i.op == pst_pkg::OP_LOAD_RESULT) begin
      rsp_st_q   <= st_q;
      rsp_cnt_q  <= pst_pkg::CNT_W'(occ_q);
      rsp_id_q   <= oid_q;
      rsp_prio_q <= oprio_q;
      rsp_pos_q  <= pst_pkg::POS_W'(pos_q);
    end
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign rsp_status_o = rsp_st_q;
  assign rsp_count_o  = rsp_cnt_q;
  assign rsp_id_o     = rsp_id_q;
  assign rsp_prio_o   = rsp_prio_q;
  assign rsp_pos_o    = rsp_pos_q;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CAP)
    else $error("occupancy above capacity");

  a_place_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == pst_pkg::OP_INS_PLACE) |-> (occ_q < CAP && ptr_q <= occ_q))
    else $error("insert placed into a full table or past the end");

  a_place_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == pst_pkg::OP_INS_PLACE) |=> (occ_q == $past(occ_q) + ONE))
    else $error("occupancy did not grow after insert");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == pst_pkg::OP_LOAD_RESULT) |-> (!rsp_valid_q || rsp_ready_i))
    else $error("result loaded over an untaken result");

  a_remove_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == pst_pkg::OP_REM_FINISH) |-> (occ_q != '0))
    else $error("remove finished on an empty table");
`endif

endmodule

// ===== rtl/pst_ctrl.sv =====
// ----------------------------------------------------------------------------
// pst_ctrl: command sequencer for the priority sorted table
// walks read, search, shift, remove and result phases, one command per cycle
// ----------------------------------------------------------------------------
module pst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  pst_pkg::dp_stat_t stat_i,
  output pst_pkg::dp_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_READ     = 3'd2;
  localparam logic [2:0] S_SEARCH   = 3'd3;
  localparam logic [2:0] S_SHIFT    = 3'd4;
  localparam logic [2:0] S_REMOVE   = 3'd5;
  localparam logic [2:0] S_RESULT   = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_ready_o = 1'b0;
    cmd_o.op    = pst_pkg::OP_NONE;
    cmd_o.code  = pst_pkg::ST_OK;
    unique case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_o.op = pst_pkg::OP_CAPTURE;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.kind)
          pst_pkg::KIND_INSERT, pst_pkg::KIND_REMOVE: state_d = S_SEARCH;
          pst_pkg::KIND_CLEAR: begin
            cmd_o.op = pst_pkg::OP_CLEAR;
            state_d  = S_RESULT;
          end
          default: begin
            cmd_o.op = pst_pkg::OP_READ_ISSUE;
            state_d  = S_READ;
          end
        endcase
      end
      S_READ: begin
        cmd_o.op = pst_pkg::OP_READ_TAKE;
        state_d  = S_RESULT;
      end
      S_SEARCH: begin
        priority if (stat_i.hit) begin
          if (stat_i.kind == pst_pkg::KIND_INSERT) begin
            cmd_o.op = pst_pkg::OP_DUP;
            state_d  = S_RESULT;
          end else begin
            cmd_o.op = pst_pkg::OP_REM_START;
            state_d  = S_REMOVE;
          end
        end else if (stat_i.more) begin
          cmd_o.op = pst_pkg::OP_SCAN;
        end else if (stat_i.kind == pst_pkg::KIND_INSERT) begin
          if (stat_i.full) begin
            cmd_o.op   = pst_pkg::OP_FAIL;
            cmd_o.code = pst_pkg::ST_FULL;
            state_d    = S_RESULT;
          end else begin
            cmd_o.op = pst_pkg::OP_INS_START;
            state_d  = S_SHIFT;
          end
        end else begin
          cmd_o.op   = pst_pkg::OP_FAIL;
          cmd_o.code = pst_pkg::ST_NOT_FOUND;
          state_d    = S_RESULT;
        end
      end
      S_SHIFT: begin
        if (stat_i.ptr_zero || !stat_i.behind) begin
          cmd_o.op = pst_pkg::OP_INS_PLACE;
          state_d  = S_RESULT;
        end else begin
          cmd_o.op = pst_pkg::OP_INS_SHIFT;
        end
      end
      S_REMOVE: begin
        if (stat_i.rem_more) begin
          cmd_o.op = pst_pkg::OP_REM_SHIFT;
        end else begin
          cmd_o.op = pst_pkg::OP_REM_FINISH;
          state_d  = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat_i.rsp_free) begin
          cmd_o.op = pst_pkg::OP_LOAD_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== dv/priority_sorted_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_sorted_table_test: self-checking bench for the priority sorted table
// a directed table of commands runs first, then phases of random commands,
// each phase under a fresh sort order; a local copy of the table predicts
// every result item, which is checked field by field as it leaves the block
// ----------------------------------------------------------------------------
module priority_sorted_table_test;

  localparam int unsigned CAPACITY = pst_pkg::CAPACITY_DEF;
  localparam int DIRECTED_ROWS = 21;
  localparam int RANDOM_ITEMS = 450;
  // worst case walk of the table: search plus shift, with some margin
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;

  typedef struct packed {
    pst_pkg::kind_e                    kind;
    logic [pst_pkg::ID_W-1:0]          id;
    logic signed [pst_pkg::PRIO_W-1:0] prio;
    logic [pst_pkg::RPOS_W-1:0]        rpos;
  } table_cmd_t;

  typedef struct packed {
    pst_pkg::status_e                  status;
    logic [pst_pkg::CNT_W-1:0]         count;
    logic [pst_pkg::ID_W-1:0]          id;
    logic signed [pst_pkg::PRIO_W-1:0] prio;
    logic [pst_pkg::POS_W-1:0]         pos;
  } table_result_t;

  // one row of the directed part; known marks a result typed in by hand
  typedef struct packed {
    table_cmd_t    cmd;
    logic          known;
    table_result_t want;
  } directed_row_t;

  localparam table_result_t NO_RESULT = '0;

  // starts from reset, descending order; rows marked known carry their result
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // empty table: read, remove and clear
    '{'{pst_pkg::KIND_READ,   16'h0000, 16'sh0000, 6'd0},  1'b1,
      '{pst_pkg::ST_EMPTY,     7'd0, 16'h0000, 16'sh0000, 6'd0}},
    '{'{pst_pkg::KIND_REMOVE, 16'h0005, 16'sh0000, 6'd0},  1'b1,
      '{pst_pkg::ST_NOT_FOUND, 7'd0, 16'h0000, 16'sh0000, 6'd0}},
    '{'{pst_pkg::KIND_CLEAR,  16'h0000, 16'sh0000, 6'd63}, 1'b1,
      '{pst_pkg::ST_OK,        7'd0, 16'h0000, 16'sh0000, 6'd0}},
    // extreme ids and priorities
    '{'{pst_pkg::KIND_INSERT, 16'hffff, 16'sh7fff, 6'd0},  1'b1,
      '{pst_pkg::ST_OK,        7'd1, 16'h0000, 16'sh0000, 6'd0}},
    '{'{pst_pkg::KIND_INSERT, 16'h0000, 16'sh8000, 6'd0},  1'b1,
      '{pst_pkg::ST_OK,        7'd2, 16'h0000, 16'sh0000, 6'd1}},
    '{'{pst_pkg::KIND_INSERT, 16'h1234, 16'sh0000, 6'd0},  1'b1,
      '{pst_pkg::ST_OK,        7'd3, 16'h0000, 16'sh0000, 6'd1}},
    // equal priority lands behind the earlier arrival
    '{'{pst_pkg::KIND_INSERT, 16'h5555, 16'sh0000, 6'd0},  1'b1,
      '{pst_pkg::ST_OK,        7'd4, 16'h0000, 16'sh0000, 6'd2}},
    // duplicate id reports where the held entry stands
    '{'{pst_pkg::KIND_INSERT, 16'hffff, 16'sh0005, 6'd0},  1'b1,
      '{pst_pkg::ST_DUPLICATE, 7'd4, 16'h0000, 16'sh0000, 6'd0}},
    '{'{pst_pkg::KIND_READ,   16'h0000, 16'sh0000, 6'd63}, 1'b1,
      '{pst_pkg::ST_EMPTY,     7'd4, 16'h0000, 16'sh0000, 6'd0}},
    '{'{pst_pkg::KIND_READ,   16'h0000, 16'sh0000, 6'd0},  1'b1,
      '{pst_pkg::ST_OK,        7'd4, 16'hffff, 16'sh7fff, 6'd0}},
    '{'{pst_pkg::KIND_READ,   16'h0000, 16'sh0000, 6'd3},  1'b1,
      '{pst_pkg::ST_OK,        7'd4, 16'h0000, 16'sh8000, 6'd0}},
    '{'{pst_pkg::KIND_REMOVE, 16'h1234, 16'sh0000, 6'd0},  1'b1,
      '{pst_pkg::ST_OK,        7'd3, 16'h0000, 16'sh0000, 6'd1}},
    '{'{pst_pkg::KIND_REMOVE, 16'h1234, 16'sh0000, 6'd0},  1'b1,
      '{pst_pkg::ST_NOT_FOUND, 7'd3, 16'h0000, 16'sh0000, 6'd0}},
    // from here the local table predicts, up to the closing clear and read
    '{'{pst_pkg::KIND_INSERT, 16'haaaa, 16'shffff, 6'd9},  1'b0, NO_RESULT},
    '{'{pst_pkg::KIND_INSERT, 16'h0001, 16'sh8000, 6'd0},  1'b0, NO_RESULT},
    '{'{pst_pkg::KIND_READ,   16'h7777, 16'sh1111, 6'd4},  1'b0, NO_RESULT},
    '{'{pst_pkg::KIND_REMOVE, 16'hffff, 16'sh0000, 6'd0},  1'b0, NO_RESULT},
    '{'{pst_pkg::KIND_REMOVE, 16'h0001, 16'sh0000, 6'd0},  1'b0, NO_RESULT},
    '{'{pst_pkg::KIND_INSERT, 16'h7fff, 16'sh7fff, 6'd0},  1'b0, NO_RESULT},
    '{'{pst_pkg::KIND_CLEAR,  16'hffff, 16'shffff, 6'd63}, 1'b1,
      '{pst_pkg::ST_OK,        7'd0, 16'h0000, 16'sh0000, 6'd0}},
    '{'{pst_pkg::KIND_READ,   16'h0000, 16'sh0000, 6'd0},  1'b1,
      '{pst_pkg::ST_EMPTY,     7'd0, 16'h0000, 16'sh0000, 6'd0}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #6 clk = ~clk;

  pst_cmd_if cmd_ch ();
  pst_rsp_if rsp_ch ();
  pst_cfg_if cfg_ch ();

  priority_sorted_table #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_ch),
    .rsp_o (rsp_ch),
    .cfg_i (cfg_ch)
  );

  // local copy of the table, updated at each accepted command item
  logic [pst_pkg::ID_W-1:0]          held_id   [CAPACITY];
  logic signed [pst_pkg::PRIO_W-1:0] held_prio [CAPACITY];
  int                                held_count = 0;
  logic                              ascending_mode = 1'b0;

  table_result_t pending_results [$];
  int            mismatch_count = 0;
  int            accepted_items = 0;
  int            sender_idle_pct = 9;
  int            receiver_idle_pct = 56;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $realtime, what);
    mismatch_count++;
  endtask

  // applies one command to the local table and returns its result item
  function automatic table_result_t apply_command(input table_cmd_t c);
    table_result_t r;
    int            slot;
    int            k;
    logic          hit;
    r = '0;
    r.status = pst_pkg::ST_OK;
    slot = 0;
    hit = 1'b0;
    if (c.kind == pst_pkg::KIND_INSERT || c.kind == pst_pkg::KIND_REMOVE) begin
      for (int i = 0; i < held_count; i++) begin
        if (!hit && held_id[i] == c.id) begin
          hit = 1'b1;
          slot = i;
        end
      end
    end
    case (c.kind)
      pst_pkg::KIND_INSERT: begin
        if (hit) begin
          r.status = pst_pkg::ST_DUPLICATE;
          r.pos = pst_pkg::POS_W'(slot);
        end else if (held_count >= CAPACITY) begin
          r.status = pst_pkg::ST_FULL;
        end else begin
          // walk from the tail past every entry ranked strictly behind
          k = held_count;
          while (k > 0 && (ascending_mode ? held_prio[k-1] > c.prio
                                          : held_prio[k-1] < c.prio)) begin
            held_id[k] = held_id[k-1];
            held_prio[k] = held_prio[k-1];
            k--;
          end
          held_id[k] = c.id;
          held_prio[k] = c.prio;
          held_count++;
          r.pos = pst_pkg::POS_W'(k);
        end
      end
      pst_pkg::KIND_REMOVE: begin
        if (!hit) begin
          r.status = pst_pkg::ST_NOT_FOUND;
        end else begin
          for (int i = slot; i + 1 < held_count; i++) begin
            held_id[i] = held_id[i+1];
            held_prio[i] = held_prio[i+1];
          end
          held_count--;
          r.pos = pst_pkg::POS_W'(slot);
        end
      end
      pst_pkg::KIND_CLEAR: begin
        held_count = 0;
      end
      default: begin
        if (c.rpos < held_count) begin
          r.id = held_id[c.rpos];
          r.prio = held_prio[c.rpos];
        end else begin
          r.status = pst_pkg::ST_EMPTY;
        end
      end
    endcase
    r.count = pst_pkg::CNT_W'(held_count);
    return r;
  endfunction

  // an id not in the table
  function automatic logic [pst_pkg::ID_W-1:0] fresh_id();
    logic [pst_pkg::ID_W-1:0] id;
    logic                     taken;
    do begin
      id = pst_pkg::ID_W'($urandom);
      taken = 1'b0;
      for (int i = 0; i < held_count; i++) begin
        if (held_id[i] == id) taken = 1'b1;
      end
    end while (taken);
    return id;
  endfunction

  // mostly wide values, with ties near zero and the two extremes mixed in
  function automatic logic signed [pst_pkg::PRIO_W-1:0] random_priority();
    case ($urandom_range(0, 3))
      0: return pst_pkg::PRIO_W'(int'($urandom_range(0, 4)) - 2);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return pst_pkg::PRIO_W'($urandom);
    endcase
  endfunction

  // presents one command item, waits for it to be taken and predicts it;
  // called and returning just after a falling edge
  task automatic send_command(input table_cmd_t c, input logic known,
                              input table_result_t want);
    table_result_t predicted;
    table_result_t expected;
    // idling pattern by thirds of the run: sender light, then receiver
    // light, then no idling at all
    case (accepted_items * 3 / (DIRECTED_ROWS + RANDOM_ITEMS))
      0: begin
        sender_idle_pct = 9;
        receiver_idle_pct = 56;
      end
      1: begin
        sender_idle_pct = 56;
        receiver_idle_pct = 9;
      end
      default: begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
    endcase
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk);
    end
    cmd_ch.kind = c.kind;
    cmd_ch.entry_id = c.id;
    cmd_ch.entry_priority = c.prio;
    cmd_ch.read_position = c.rpos;
    cmd_ch.valid = 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    predicted = apply_command(c);
    expected = known ? want : predicted;
    pending_results = {pending_results, expected};
    accepted_items++;
    @(negedge clk);
  endtask

  // lowers valid and waits until every pending result item has left
  task automatic wait_idle();
    cmd_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // the sort order only changes while nothing is in flight
  task automatic write_order(input logic value);
    cfg_ch.ascending_order = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    ascending_mode = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // receiver side: ready toggles at the falling edge
  always @(negedge clk) begin
    rsp_ch.ready = ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  // result items are taken at the rising edge and checked in order
  always @(posedge clk) begin : result_check
    table_result_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result item with no command pending");
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    rsp_ch.status, want.status));
        if (rsp_ch.entry_count !== want.count)
          report_mismatch($sformatf("entry_count got %0d want %0d",
                                    rsp_ch.entry_count, want.count));
        if (rsp_ch.out_id !== want.id)
          report_mismatch($sformatf("out_id got %h want %h",
                                    rsp_ch.out_id, want.id));
        if (rsp_ch.out_priority !== want.prio)
          report_mismatch($sformatf("out_priority got %0d want %0d",
                                    rsp_ch.out_priority, want.prio));
        if (rsp_ch.final_position !== want.pos)
          report_mismatch($sformatf("final_position got %0d want %0d",
                                    rsp_ch.final_position, want.pos));
      end
    end
  end

  initial begin : stimulus
    table_cmd_t c;
    int         phase;
    int         pick;
    cmd_ch.valid = 1'b0;
    cmd_ch.kind = pst_pkg::KIND_INSERT;
    cmd_ch.entry_id = '0;
    cmd_ch.entry_priority = '0;
    cmd_ch.read_position = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.ascending_order = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // descending order, written explicitly even though it is the reset value
    write_order(1'b0);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_command(directed_rows[i].cmd, directed_rows[i].known,
                   directed_rows[i].want);
    end

    // random phases; every third one fills the table to the brim
    phase = 0;
    while (accepted_items < DIRECTED_ROWS + RANDOM_ITEMS) begin
      wait_idle();
      if (phase % 3 == 1) begin
        write_order(1'((phase / 3) % 2));
        c.rpos = pst_pkg::RPOS_W'($urandom);
        c.kind = pst_pkg::KIND_INSERT;
        while (held_count < CAPACITY) begin
          c.id = fresh_id();
          c.prio = random_priority();
          send_command(c, 1'b0, NO_RESULT);
        end
        // full table: new id dropped, held id still reported as duplicate
        c.id = fresh_id();
        send_command(c, 1'b0, NO_RESULT);
        c.id = held_id[$urandom_range(0, held_count - 1)];
        send_command(c, 1'b0, NO_RESULT);
        // last position, then one slot freed and refilled
        c.kind = pst_pkg::KIND_READ;
        c.rpos = pst_pkg::RPOS_W'(CAPACITY - 1);
        send_command(c, 1'b0, NO_RESULT);
        c.kind = pst_pkg::KIND_REMOVE;
        c.id = held_id[$urandom_range(0, held_count - 1)];
        send_command(c, 1'b0, NO_RESULT);
        c.kind = pst_pkg::KIND_READ;
        send_command(c, 1'b0, NO_RESULT);
        c.kind = pst_pkg::KIND_INSERT;
        c.id = fresh_id();
        c.prio = random_priority();
        send_command(c, 1'b0, NO_RESULT);
        repeat (6) begin
          c.kind = pst_pkg::KIND_READ;
          c.rpos = pst_pkg::RPOS_W'($urandom);
          send_command(c, 1'b0, NO_RESULT);
        end
      end else begin
        write_order(1'($urandom_range(0, 1)));
        repeat (40) begin
          // unused fields stay random as noise
          c.kind = pst_pkg::kind_e'($urandom_range(0, 3));
          c.id = pst_pkg::ID_W'($urandom);
          c.prio = pst_pkg::PRIO_W'($urandom);
          c.rpos = pst_pkg::RPOS_W'($urandom);
          pick = $urandom_range(0, 99);
          if (pick < 45) begin
            c.kind = pst_pkg::KIND_INSERT;
            if (held_count > 0 && $urandom_range(0, 3) == 0)
              c.id = held_id[$urandom_range(0, held_count - 1)];
            c.prio = random_priority();
          end else if (pick < 70) begin
            c.kind = pst_pkg::KIND_REMOVE;
            if (held_count > 0 && $urandom_range(0, 3) != 0)
              c.id = held_id[$urandom_range(0, held_count - 1)];
          end else if (pick < 95) begin
            c.kind = pst_pkg::KIND_READ;
            if (held_count > 0 && $urandom_range(0, 4) != 0)
              c.rpos = pst_pkg::RPOS_W'($urandom_range(0, held_count - 1));
          end else begin
            c.kind = pst_pkg::KIND_CLEAR;
          end
          send_command(c, 1'b0, NO_RESULT);
        end
      end
      phase++;
    end

    // drain, then watch a while longer for stray result items
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #10ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
